### sv/imts_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none
package imts_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int BUF_DEPTH_DEF   = 16;

   // Entries in the queue that sits between the front end and the back end.
   localparam int CMDQ_DEPTH = 2;

   // Two-wire status codes with the prescaler bits masked off.
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_RSTART     = 8'h10;
   localparam logic [7:0] ST_MT_ADDR_ACK = 8'h18;
   localparam logic [7:0] ST_MT_DATA_ACK = 8'h28;
   localparam logic [7:0] ST_MR_ADDR_ACK = 8'h40;
   localparam logic [7:0] ST_MR_DATA_ACK = 8'h50;
   localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

   typedef enum logic [1:0] {
      FN_LOAD   = 2'd0,
      FN_SUBMIT = 2'd1,
      FN_EVENT  = 2'd2,
      FN_CANCEL = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CL_ADDR  = 2'd0,
      CL_DATA  = 2'd1,
      CL_RACK  = 2'd2,
      CL_OTHER = 2'd3
   } code_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_NOACK = 3'd3,
      CMD_ACK   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      DS_FINISHED  = 2'd0,
      DS_BUS_ERROR = 2'd1,
      DS_CANCELLED = 2'd2,
      DS_REJECTED  = 2'd3
   } done_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_EXEC   = 2'd1,
      BK_SECOND = 2'd2
   } back_state_type;

   typedef struct packed {
      func_type    func;
      code_type    code;
      logic [3:0]  byte_index;
      logic [7:0]  byte_value;
      logic [6:0]  device_address;
      logic [4:0]  write_count;
      logic [4:0]  read_count;
   } item_type;

   typedef struct packed {
      logic       valid;
      cmd_type    bus_command;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_valid;
      done_type   done_status;
      logic [1:0] done_slot;
      logic       last;
   } rsp_type;

endpackage
`default_nettype wire

### sv/imts_front.sv
// Front end: takes requests, classifies the bus status code and holds the item
// until the command queue has room. Depends on imts_pkg.
`default_nettype none
module imts_front
   import imts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_func,
   input  wire logic [3:0] req_byte_index,
   input  wire logic [7:0] req_byte_value,
   input  wire logic [6:0] req_device_address,
   input  wire logic [4:0] req_write_count,
   input  wire logic [4:0] req_read_count,
   input  wire logic [7:0] req_bus_status,
   input  wire logic       q_full,
   output logic            push,
   output item_type        push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   code_type code;
   logic     accept;

   always_comb begin
      unique case (req_bus_status) inside
         ST_START, ST_RSTART: code = CL_ADDR;
         ST_MT_ADDR_ACK, ST_MT_DATA_ACK, ST_MR_DATA_ACK, ST_MR_DATA_NACK: code = CL_DATA;
         ST_MR_ADDR_ACK: code = CL_RACK;
         default: code = CL_OTHER;
      endcase
   end

   assign push   = valid_ff && !q_full;
   assign busy   = valid_ff && !push;
   assign accept = start && !busy;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in               = 1'b1;
         item_in.func           = func_type'(req_func);
         item_in.code           = code;
         item_in.byte_index     = req_byte_index;
         item_in.byte_value     = req_byte_value;
         item_in.device_address = req_device_address;
         item_in.write_count    = req_write_count;
         item_in.read_count     = req_read_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_item = item_ff;

endmodule
`default_nettype wire

### sv/imts_queue.sv
// Short command queue between the front end and the back end.
// Depends on imts_pkg for the item type and its depth.
`default_nettype none
module imts_queue
   import imts_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   input  wire logic pop,
   output item_type  head_item,
   output logic      full,
   output logic      empty
);

   localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CW = $clog2(CMDQ_DEPTH + 1);

   item_type        entry_ff [CMDQ_DEPTH];
   logic [PW-1:0]   rd_ff, rd_in, wr_ff, wr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      logic [PW:0] s;
      s = {1'b0, p} + 1'b1;
      if (s == (PW+1)'(CMDQ_DEPTH)) begin
         s = '0;
      end
      return s[PW-1:0];
   endfunction

   assign full      = (cnt_ff == CW'(CMDQ_DEPTH));
   assign empty     = (cnt_ff == '0);
   assign head_item = entry_ff[rd_ff];

   always_comb begin
      rd_in  = pop ? bump(rd_ff) : rd_ff;
      wr_in  = push ? bump(wr_ff) : wr_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

### sv/imts_back.sv
// Back end: holds the transfer descriptors and write buffers and sequences the
// head transfer from bus events. Depends on imts_pkg.
`default_nettype none
module imts_back
   import imts_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int BUF_DEPTH   = BUF_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_empty,
   input  item_type  q_item,
   output logic      pop,
   output rsp_type   rsp
);

   localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_N = QUEUE_DEPTH * BUF_DEPTH;
   localparam int AW    = (MEM_N > 1) ? $clog2(MEM_N) : 1;

   back_state_type state_ff, state_in;
   item_type       cur_ff;
   logic [SW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [4:0]     off_ff, off_in;
   logic           rp_ff, rp_in;

   logic [6:0]     slot_addr_ff [QUEUE_DEPTH];
   logic [4:0]     slot_wc_ff   [QUEUE_DEPTH];
   logic [4:0]     slot_rc_ff   [QUEUE_DEPTH];
   logic [7:0]     buf_mem      [MEM_N];
   logic [7:0]     rdata_ff;

   logic [SW-1:0]  tail, head_next;
   logic [SW:0]    tail_sum, head_sum;
   logic [4:0]     wc, rc, off1;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic           slot_we, buf_we, fin;
   done_type       fin_status;
   logic           fin_rxv;
   rsp_type        res, rsp_ff;

   assign wc = slot_wc_ff[head_ff];
   assign rc = slot_rc_ff[head_ff];

   always_comb begin
      tail_sum = (SW+1)'(head_ff) + (SW+1)'(count_ff);
      if (tail_sum >= (SW+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (SW+1)'(QUEUE_DEPTH);
      end
      tail     = tail_sum[SW-1:0];
      head_sum = (SW+1)'(head_ff) + 1'b1;
      if (head_sum == (SW+1)'(QUEUE_DEPTH)) begin
         head_sum = '0;
      end
      head_next = head_sum[SW-1:0];
   end

   assign rd_addr = AW'(head_ff) * AW'(BUF_DEPTH) + AW'(off_ff);
   assign wr_addr = AW'(tail) * AW'(BUF_DEPTH) + AW'(cur_ff.byte_index);
   assign off1    = off_ff + 1'b1;

   function automatic cmd_type ack_cmd(input logic [4:0] o, input logic [4:0] r);
      return (({1'b0, o} + 6'd1) == {1'b0, r}) ? CMD_NOACK : CMD_ACK;
   endfunction

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (!q_empty) state_in = BK_EXEC;
         BK_EXEC:   state_in = (fin && count_ff > CW'(1)) ? BK_SECOND : BK_IDLE;
         BK_SECOND: state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // Work on the latched item and form the result.
   always_comb begin
      pop        = (state_ff == BK_IDLE) && !q_empty;
      head_in    = head_ff;
      count_in   = count_ff;
      off_in     = off_ff;
      rp_in      = rp_ff;
      slot_we    = 1'b0;
      buf_we     = 1'b0;
      fin        = 1'b0;
      fin_status = DS_FINISHED;
      fin_rxv    = 1'b0;
      res        = '0;
      res.last   = 1'b1;
      unique case (state_ff)
         BK_EXEC: begin
            unique case (cur_ff.func)
               FN_LOAD: begin
                  buf_we = (32'(count_ff) < QUEUE_DEPTH) &&
                           (32'(cur_ff.byte_index) < BUF_DEPTH);
               end
               FN_SUBMIT: begin
                  if (32'(count_ff) >= QUEUE_DEPTH ||
                      (cur_ff.write_count == '0 && cur_ff.read_count == '0) ||
                      32'(cur_ff.write_count) > BUF_DEPTH) begin
                     res.valid       = 1'b1;
                     res.done_valid  = 1'b1;
                     res.done_status = DS_REJECTED;
                     res.done_slot   = 2'(tail);
                  end else begin
                     slot_we  = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (count_ff == '0) begin
                        off_in          = '0;
                        rp_in           = (cur_ff.write_count == '0);
                        res.valid       = 1'b1;
                        res.bus_command = CMD_START;
                     end
                  end
               end
               FN_CANCEL: begin
                  if (count_ff != '0) begin
                     fin        = 1'b1;
                     fin_status = DS_CANCELLED;
                  end
               end
               FN_EVENT: begin
                  if (count_ff != '0) begin
                     res.valid = 1'b1;
                     unique case (cur_ff.code)
                        CL_ADDR: begin
                           res.bus_command = CMD_NOACK;
                           res.tx_valid    = 1'b1;
                           res.tx_byte     = {slot_addr_ff[head_ff], rp_ff};
                        end
                        CL_RACK: res.bus_command = ack_cmd(off_ff, rc);
                        CL_DATA: begin
                           if (rp_ff) begin
                              off_in = off1;
                              if (off1 == rc) begin
                                 fin     = 1'b1;
                                 fin_rxv = 1'b1;
                              end else begin
                                 res.bus_command = ack_cmd(off1, rc);
                                 res.rx_valid    = 1'b1;
                                 res.rx_byte     = cur_ff.byte_value;
                              end
                           end else if (off_ff >= wc) begin
                              if (rc != '0) begin
                                 rp_in           = 1'b1;
                                 off_in          = '0;
                                 res.bus_command = CMD_START;
                              end else begin
                                 fin = 1'b1;
                              end
                           end else begin
                              off_in          = off1;
                              res.bus_command = CMD_NOACK;
                              res.tx_valid    = 1'b1;
                              res.tx_byte     = rdata_ff;
                           end
                        end
                        default: begin
                           fin        = 1'b1;
                           fin_status = DS_BUS_ERROR;
                        end
                     endcase
                  end
               end
               default: ;
            endcase
            if (fin) begin
               head_in         = head_next;
               count_in        = count_ff - 1'b1;
               off_in          = '0;
               rp_in           = 1'b0;
               res             = '0;
               res.valid       = 1'b1;
               res.bus_command = CMD_STOP;
               res.rx_valid    = fin_rxv;
               res.rx_byte     = fin_rxv ? cur_ff.byte_value : 8'h00;
               res.done_valid  = 1'b1;
               res.done_status = fin_status;
               res.done_slot   = 2'(head_ff);
               res.last        = (count_ff == CW'(1));
            end
         end
         BK_SECOND: begin
            // The head has already moved to the next waiting transfer.
            rp_in           = (wc == '0);
            res.valid       = 1'b1;
            res.bus_command = CMD_START;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         off_ff   <= '0;
         rp_ff    <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         off_ff   <= off_in;
         rp_ff    <= rp_in;
         rsp_ff   <= res;
      end
      if (pop) begin
         cur_ff   <= q_item;
         rdata_ff <= buf_mem[rd_addr];
      end
      if (buf_we) begin
         buf_mem[wr_addr] <= cur_ff.byte_value;
      end
      if (slot_we) begin
         slot_addr_ff[tail] <= cur_ff.device_address;
         slot_wc_ff[tail]   <= cur_ff.write_count;
         slot_rc_ff[tail]   <= cur_ff.read_count;
      end
   end

   assign rsp = rsp_ff;

endmodule
`default_nettype wire

### sv/i2c_master_transfer_sequencer.sv
// A request is registered in the front end, pushed into the queue once it has room and popped
// by an idle back end, which also reads the write buffer. The back end then forms the result,
// which is registered to the ports. A completion that starts the next transfer gives a second
// result in the cycle after. The back end pops a new item only while it is idle.
// Synchronous active-high reset empties the queue; results cannot be stalled.
`default_nettype none
module i2c_master_transfer_sequencer
   import imts_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int BUF_DEPTH   = BUF_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_func,
   input  wire logic [3:0] req_byte_index,
   input  wire logic [7:0] req_byte_value,
   input  wire logic [6:0] req_device_address,
   input  wire logic [4:0] req_write_count,
   input  wire logic [4:0] req_read_count,
   input  wire logic [7:0] req_bus_status,
   output logic            rsp_valid,
   output logic [2:0]      rsp_bus_command,
   output logic            rsp_tx_valid,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_rx_valid,
   output logic [7:0]      rsp_rx_byte,
   output logic            rsp_done_valid,
   output logic [1:0]      rsp_done_status,
   output logic [1:0]      rsp_done_slot,
   output logic            rsp_last
);

   logic     q_full, q_empty, push, pop;
   item_type push_item, head_item;
   rsp_type  rsp;

   imts_front u_front (
      .clock, .reset, .start, .busy,
      .req_func, .req_byte_index, .req_byte_value, .req_device_address,
      .req_write_count, .req_read_count, .req_bus_status,
      .q_full, .push, .push_item
   );

   imts_queue u_queue (
      .clock, .reset, .push, .push_item, .pop,
      .head_item, .full(q_full), .empty(q_empty)
   );

   imts_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .BUF_DEPTH  (BUF_DEPTH)
   ) u_back (
      .clock, .reset, .q_empty, .q_item(head_item), .pop, .rsp
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_bus_command = rsp.bus_command;
   assign rsp_tx_valid    = rsp.tx_valid;
   assign rsp_tx_byte     = rsp.tx_byte;
   assign rsp_rx_valid    = rsp.rx_valid;
   assign rsp_rx_byte     = rsp.rx_byte;
   assign rsp_done_valid  = rsp.done_valid;
   assign rsp_done_status = rsp.done_status;
   assign rsp_done_slot   = rsp.done_slot;
   assign rsp_last        = rsp.last;

endmodule
`default_nettype wire

### sv/imts_checker.sv
// Port-level checks for the I2C master transfer sequencer, bound to the top level.
// Depends on imts_pkg for the command codes.
`default_nettype none
module imts_checker
   import imts_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_bus_command,
   input wire logic       rsp_tx_valid,
   input wire logic       rsp_done_valid,
   input wire logic       rsp_last
);

   // A result that is not the last result of its request is followed by a start.
   a_second_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_bus_command == CMD_START)
      else $error("missing start after completion");

   a_done_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_valid |->
         rsp_bus_command == CMD_STOP || rsp_bus_command == CMD_NONE)
      else $error("completion without stop");

   a_tx_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> rsp_bus_command == CMD_NOACK)
      else $error("byte load with wrong command");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

endmodule

bind i2c_master_transfer_sequencer imts_checker u_imts_checker (
   .clock, .reset, .rsp_valid, .rsp_bus_command, .rsp_tx_valid,
   .rsp_done_valid, .rsp_last
);
`default_nettype wire
